### sv/hbvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbvr_pkg;

   // Widths of storage, flows and thresholds (Q16.16)
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 3;

   // Default coefficient width (Q0.16)
   localparam int COEF_BITS_DEF = 16;

   localparam logic [DATA_W-1:0] FULL_SCALE = {DATA_W{1'b1}};

   // Register reset values
   localparam logic [DATA_W-1:0] INIT_STORAGE_RESET = 32'd0;
   localparam logic [DATA_W-1:0] FAST_COEF_RESET    = 32'd39322;
   localparam logic [DATA_W-1:0] MID_COEF_RESET     = 32'd19661;
   localparam logic [DATA_W-1:0] BASE_COEF_RESET    = 32'd3277;
   localparam logic [DATA_W-1:0] UPPER_THR_RESET    = 32'd1310720;
   localparam logic [DATA_W-1:0] PERC_THR_RESET     = 32'd131072;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_STORAGE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_COEF    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_COEF     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_COEF    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_THR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERC_THR     = 3'd5;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_POST,
      ST_ADJ,
      ST_TOTAL,
      ST_DONE
   } state_type;

   // Outlet currently served by the shared multiplier
   typedef enum logic [1:0] {
      OUT_FAST,
      OUT_MID,
      OUT_BASE
   } outlet_type;

   // Sum with clip flag in the top bit
   typedef struct packed {
      logic              clip;
      logic [DATA_W-1:0] sum;
   } sat_sum_type;

   function automatic sat_sum_type sat_add(input logic [DATA_W-1:0] a,
                                           input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      sat_sum_type     r;
      s = {1'b0, a} + {1'b0, b};
      if (s[DATA_W]) begin
         r.clip = 1'b1;
         r.sum  = FULL_SCALE;
      end else begin
         r.clip = 1'b0;
         r.sum  = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/hbv_reservoir_three_outlet_routing.sv
// Steps: load, then multiply and post per outlet from the starting band down to base
// (an adjust step after fast), then total and finish; an order error skips to finish.
// Throughput: one item at a time; the next beat can be taken in the cycle after the
// result is loaded into the output register. One 32 x COEF_BITS multiplier serves all
// outlets. Reset: synchronous active high; registers return to defaults,
// storage empties and the next item reloads the initial storage.
`timescale 1ns / 1ps
`default_nettype none

module hbv_reservoir_three_outlet_routing #(
   parameter int COEF_BITS = hbvr_pkg::COEF_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [hbvr_pkg::DATA_W-1:0]    req_runoff_in,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [hbvr_pkg::DATA_W-1:0]         rsp_total_flow,
   output logic [hbvr_pkg::DATA_W-1:0]         rsp_fast_flow,
   output logic [hbvr_pkg::DATA_W-1:0]         rsp_mid_flow,
   output logic [hbvr_pkg::DATA_W-1:0]         rsp_base_flow,
   output logic [hbvr_pkg::DATA_W-1:0]         rsp_storage_out,
   output logic                                rsp_saturated,
   output logic                                rsp_config_error,
   // configuration channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hbvr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hbvr_pkg::DATA_W-1:0]    csr_data
);
   import hbvr_pkg::*;

   localparam int PROD_W = DATA_W + COEF_BITS;

   localparam logic [COEF_BITS-1:0] FAST_RST = COEF_BITS'(FAST_COEF_RESET);
   localparam logic [COEF_BITS-1:0] MID_RST  = COEF_BITS'(MID_COEF_RESET);
   localparam logic [COEF_BITS-1:0] BASE_RST = COEF_BITS'(BASE_COEF_RESET);

   // configuration registers
   logic [DATA_W-1:0]    init_ff;
   logic [COEF_BITS-1:0] fast_ff;
   logic [COEF_BITS-1:0] mid_ff;
   logic [COEF_BITS-1:0] base_ff;
   logic [DATA_W-1:0]    upper_ff;
   logic [DATA_W-1:0]    perc_ff;

   // sequencer and datapath
   state_type         state_ff, state_in;
   outlet_type        outlet_ff, outlet_in;
   logic [DATA_W-1:0] runoff_ff, runoff_in;
   logic [DATA_W-1:0] s_ff, s_in;
   logic [DATA_W-1:0] amt_ff, amt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] q0_ff, q0_in;
   logic [DATA_W-1:0] q1_ff, q1_in;
   logic [DATA_W-1:0] q2_ff, q2_in;
   logic [DATA_W-1:0] total_ff, total_in;
   logic              clip_ff, clip_in;
   logic              err_ff, err_in;

   // reservoir state
   logic [DATA_W-1:0] storage_ff;
   logic              started_ff;

   // output register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_total_ff;
   logic [DATA_W-1:0] rsp_fast_ff;
   logic [DATA_W-1:0] rsp_mid_ff;
   logic [DATA_W-1:0] rsp_base_ff;
   logic [DATA_W-1:0] rsp_storage_ff;
   logic              rsp_sat_ff;
   logic              rsp_err_ff;

   // combinational helpers
   logic              req_take;
   logic              rsp_free;
   logic              out_load;
   logic              commit;
   logic [DATA_W-1:0] start_s;
   logic              order_ok;
   logic [DATA_W-1:0] thr_sel;
   logic [COEF_BITS-1:0] coef_sel;
   logic [DATA_W-1:0] q_cur;
   logic [DATA_W-1:0] sub_a, sub_b, diff;
   logic [DATA_W-1:0] add_b;
   sat_sum_type       add_r;
   logic [DATA_W+1:0] tot3;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign start_s  = started_ff ? storage_ff : init_ff;
   assign order_ok = (fast_ff > mid_ff) && (mid_ff > base_ff) && (upper_ff > perc_ff);
   assign q_cur    = prod_ff[COEF_BITS +: DATA_W];
   assign csr_ready = 1'b1;

   // select threshold and coefficient of the current outlet
   always_comb begin
      case (outlet_ff)
         OUT_FAST: begin
            thr_sel  = upper_ff;
            coef_sel = fast_ff;
         end
         OUT_MID: begin
            thr_sel  = perc_ff;
            coef_sel = mid_ff;
         end
         default: begin
            thr_sel  = '0;
            coef_sel = base_ff;
         end
      endcase
   end

   // shared subtract and saturating add
   always_comb begin
      case (state_ff)
         ST_LOAD: begin
            sub_a = s_ff;
            sub_b = thr_sel;
            add_b = runoff_ff;
         end
         ST_POST: begin
            sub_a = amt_ff;
            sub_b = q_cur;
            add_b = thr_sel;
         end
         default: begin
            sub_a = s_ff;
            sub_b = perc_ff;
            add_b = thr_sel;
         end
      endcase
      diff  = sub_a - sub_b;
      add_r = sat_add(diff, add_b);
   end

   assign tot3 = {2'b00, q0_ff} + {2'b00, q1_ff} + {2'b00, q2_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_LOAD;
         ST_LOAD:  state_in = err_ff ? ST_DONE : ST_MUL;
         ST_MUL:   state_in = ST_POST;
         ST_POST: begin
            case (outlet_ff)
               OUT_FAST: state_in = ST_ADJ;
               OUT_MID:  state_in = ST_MUL;
               default:  state_in = ST_TOTAL;
            endcase
         end
         ST_ADJ:   state_in = ST_MUL;
         ST_TOTAL: state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_DONE: out_load  = rsp_free;
         default: req_stall = 1'b1;
      endcase
      commit = out_load && !err_ff;
   end

   // datapath next values
   always_comb begin
      outlet_in = outlet_ff;
      runoff_in = runoff_ff;
      s_in      = s_ff;
      amt_in    = amt_ff;
      prod_in   = prod_ff;
      q0_in     = q0_ff;
      q1_in     = q1_ff;
      q2_in     = q2_ff;
      total_in  = total_ff;
      clip_in   = clip_ff;
      err_in    = err_ff;
      case (state_ff)
         ST_IDLE: begin
            // capture the beat and pick the starting band
            if (req_take) begin
               runoff_in = req_runoff_in;
               s_in      = start_s;
               err_in    = !order_ok;
               clip_in   = 1'b0;
               q0_in     = '0;
               q1_in     = '0;
               q2_in     = '0;
               total_in  = '0;
               if (start_s > upper_ff) begin
                  outlet_in = OUT_FAST;
               end else if (start_s > perc_ff) begin
                  outlet_in = OUT_MID;
               end else begin
                  outlet_in = OUT_BASE;
               end
            end
         end
         ST_LOAD: begin
            // excess over the band threshold plus runoff
            if (!err_ff) begin
               amt_in  = add_r.sum;
               clip_in = clip_ff | add_r.clip;
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(amt_ff) * PROD_W'(coef_sel);
         end
         ST_POST: begin
            // take the outlet flow and restore the threshold
            case (outlet_ff)
               OUT_FAST: begin
                  q0_in   = q_cur;
                  s_in    = add_r.sum;
                  clip_in = clip_ff | add_r.clip;
               end
               OUT_MID: begin
                  q1_in     = q_cur;
                  s_in      = add_r.sum;
                  amt_in    = add_r.sum;
                  clip_in   = clip_ff | add_r.clip;
                  outlet_in = OUT_BASE;
               end
               default: begin
                  q2_in = q_cur;
                  s_in  = add_r.sum;
               end
            endcase
         end
         ST_ADJ: begin
            // excess over the percolation level feeds the mid outlet
            amt_in    = diff;
            outlet_in = OUT_MID;
         end
         ST_TOTAL: begin
            if (|tot3[DATA_W+1:DATA_W]) begin
               total_in = FULL_SCALE;
               clip_in  = 1'b1;
            end else begin
               total_in = tot3[DATA_W-1:0];
            end
         end
         default: begin
            clip_in = clip_ff;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= INIT_STORAGE_RESET;
         fast_ff  <= FAST_RST;
         mid_ff   <= MID_RST;
         base_ff  <= BASE_RST;
         upper_ff <= UPPER_THR_RESET;
         perc_ff  <= PERC_THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INIT_STORAGE: init_ff  <= csr_data;
            CSR_FAST_COEF:    fast_ff  <= csr_data[COEF_BITS-1:0];
            CSR_MID_COEF:     mid_ff   <= csr_data[COEF_BITS-1:0];
            CSR_BASE_COEF:    base_ff  <= csr_data[COEF_BITS-1:0];
            CSR_UPPER_THR:    upper_ff <= csr_data;
            CSR_PERC_THR:     perc_ff  <= csr_data;
            default:          init_ff  <= init_ff;
         endcase
      end
   end

   // sequencer and reservoir state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
         storage_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            storage_ff <= s_ff;
            started_ff <= 1'b1;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      outlet_ff <= outlet_in;
      runoff_ff <= runoff_in;
      s_ff      <= s_in;
      amt_ff    <= amt_in;
      prod_ff   <= prod_in;
      q0_ff     <= q0_in;
      q1_ff     <= q1_in;
      q2_ff     <= q2_in;
      total_ff  <= total_in;
      clip_ff   <= clip_in;
      err_ff    <= err_in;
   end

   // output register: hold the beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_total_ff   <= total_ff;
         rsp_fast_ff    <= q0_ff;
         rsp_mid_ff     <= q1_ff;
         rsp_base_ff    <= q2_ff;
         rsp_storage_ff <= s_ff;
         rsp_sat_ff     <= clip_ff;
         rsp_err_ff     <= err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_flow   = rsp_total_ff;
   assign rsp_fast_flow    = rsp_fast_ff;
   assign rsp_mid_flow     = rsp_mid_ff;
   assign rsp_base_flow    = rsp_base_ff;
   assign rsp_storage_out  = rsp_storage_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_config_error = rsp_err_ff;

   // an order error reports no flow and no clip
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |->
         rsp_total_ff == '0 && rsp_fast_ff == '0 && rsp_mid_ff == '0 &&
         rsp_base_ff == '0 && !rsp_sat_ff)
      else $error("order error result carries flow");

   // the total never falls below any single outlet
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         rsp_total_ff >= rsp_fast_ff && rsp_total_ff >= rsp_mid_ff &&
         rsp_total_ff >= rsp_base_ff)
      else $error("total below an outlet flow");

   // a coefficient below one never drains more than the amount
   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POST |-> q_cur <= amt_ff)
      else $error("outlet drains more than its amount");

   // a result beat appears only from the finish step
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside finish step");

   // the reservoir starts only on a committed item
   a_start_src: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> $past(state_ff == ST_DONE && !err_ff))
      else $error("storage started without a valid item");

endmodule

`default_nettype wire

### bench/tb_hbv_reservoir_three_outlet_routing.sv
`timescale 1ns / 1ps

module tb_hbv_reservoir_three_outlet_routing;
   import hbvr_pkg::*;

   localparam int COEF_W         = COEF_BITS_DEF;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 240;

   // Idling schemes for the two channels
   localparam int MODE_STEADY          = 0;
   localparam int MODE_SENDER_GAPS     = 1;
   localparam int MODE_RECEIVER_STALLS = 2;
   localparam int MODE_BOTH            = 3;

   typedef struct packed {
      logic [DATA_W-1:0] total;
      logic [DATA_W-1:0] fast;
      logic [DATA_W-1:0] mid;
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] stor;
      logic              sat;
      logic              err;
   } flows_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DATA_W-1:0]    req_runoff_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DATA_W-1:0]    rsp_total_flow;
   logic [DATA_W-1:0]    rsp_fast_flow;
   logic [DATA_W-1:0]    rsp_mid_flow;
   logic [DATA_W-1:0]    rsp_base_flow;
   logic [DATA_W-1:0]    rsp_storage_out;
   logic                 rsp_saturated;
   logic                 rsp_config_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;

   // Predictor copy of the registers and the reservoir
   logic [DATA_W-1:0] cfg_init  = INIT_STORAGE_RESET;
   logic [COEF_W-1:0] cfg_fast  = FAST_COEF_RESET[COEF_W-1:0];
   logic [COEF_W-1:0] cfg_mid   = MID_COEF_RESET[COEF_W-1:0];
   logic [COEF_W-1:0] cfg_base  = BASE_COEF_RESET[COEF_W-1:0];
   logic [DATA_W-1:0] cfg_upper = UPPER_THR_RESET;
   logic [DATA_W-1:0] cfg_perc  = PERC_THR_RESET;
   logic [DATA_W-1:0] tank_level  = '0;
   logic              tank_filled = 1'b0;

   logic [DATA_W-1:0] runoff_backlog[$];
   logic [DATA_W-1:0] directed_runoff[$];
   flows_type         expected_flows[$];

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int hold_requests   = 0;
   int holds_served    = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;

   int failures      = 0;
   int n_results     = 0;
   int n_settings    = 0;
   int n_fast_steps  = 0;
   int n_mid_steps   = 0;
   int n_base_steps  = 0;
   int n_order_err   = 0;
   int n_clipped     = 0;

   hbv_reservoir_three_outlet_routing u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_runoff_in    (req_runoff_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_total_flow   (rsp_total_flow),
      .rsp_fast_flow    (rsp_fast_flow),
      .rsp_mid_flow     (rsp_mid_flow),
      .rsp_base_flow    (rsp_base_flow),
      .rsp_storage_out  (rsp_storage_out),
      .rsp_saturated    (rsp_saturated),
      .rsp_config_error (rsp_config_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Add with the carry kept in the top bit; clip the sum at full scale
   function automatic logic [DATA_W:0] add_clip(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] w;
      w = {1'b0, a} + {1'b0, b};
      return w[DATA_W] ? {1'b1, FULL_SCALE} : w;
   endfunction

   // Outlet flow: amount times a Q0 coefficient, truncated
   function automatic logic [DATA_W-1:0] outlet_draw(input logic [DATA_W-1:0] amount,
                                                     input logic [COEF_W-1:0] k);
      logic [DATA_W+COEF_W-1:0] p;
      p = amount * k;
      return p[COEF_W +: DATA_W];
   endfunction

   // Route one runoff sample through the reservoir and advance its level
   function automatic flows_type route_step(input logic [DATA_W-1:0] runoff);
      flows_type         r;
      logic [DATA_W-1:0] lvl;
      logic [DATA_W-1:0] amt;
      logic [DATA_W:0]   t;
      logic              hit;
      r   = '0;
      hit = 1'b0;
      lvl = tank_filled ? tank_level : cfg_init;
      if (!(cfg_fast > cfg_mid && cfg_mid > cfg_base && cfg_upper > cfg_perc)) begin
         // bad order: report the starting level, touch nothing
         r.stor = lvl;
         r.err  = 1'b1;
         n_order_err++;
         return r;
      end
      if (lvl > cfg_upper) begin
         n_fast_steps++;
         t      = add_clip(lvl - cfg_upper, runoff);
         hit    = hit | t[DATA_W];
         amt    = t[DATA_W-1:0];
         r.fast = outlet_draw(amt, cfg_fast);
         t      = add_clip(amt - r.fast, cfg_upper);
         hit    = hit | t[DATA_W];
         lvl    = t[DATA_W-1:0];
         amt    = lvl - cfg_perc;
         r.mid  = outlet_draw(amt, cfg_mid);
         lvl    = (amt - r.mid) + cfg_perc;
         r.base = outlet_draw(lvl, cfg_base);
         lvl    = lvl - r.base;
      end else if (lvl > cfg_perc) begin
         n_mid_steps++;
         t      = add_clip(lvl - cfg_perc, runoff);
         hit    = hit | t[DATA_W];
         amt    = t[DATA_W-1:0];
         r.mid  = outlet_draw(amt, cfg_mid);
         t      = add_clip(amt - r.mid, cfg_perc);
         hit    = hit | t[DATA_W];
         lvl    = t[DATA_W-1:0];
         r.base = outlet_draw(lvl, cfg_base);
         lvl    = lvl - r.base;
      end else begin
         n_base_steps++;
         t      = add_clip(lvl, runoff);
         hit    = hit | t[DATA_W];
         amt    = t[DATA_W-1:0];
         r.base = outlet_draw(amt, cfg_base);
         lvl    = amt - r.base;
      end
      t       = add_clip(r.fast, r.mid);
      hit     = hit | t[DATA_W];
      t       = add_clip(t[DATA_W-1:0], r.base);
      hit     = hit | t[DATA_W];
      r.total = t[DATA_W-1:0];
      r.stor  = lvl;
      r.sat   = hit;
      if (hit) n_clipped++;
      tank_level  = lvl;
      tank_filled = 1'b1;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Driver: advance to the next runoff beat once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (runoff_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_runoff_in <= runoff_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: predict on each accepted runoff beat, check each result beat
   always @(posedge clock) begin
      flows_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_flows.push_back(route_step(req_runoff_in));
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_flows.size() == 0) begin
               failures++;
               $display("%0t result beat with nothing expected: total %h storage %h",
                        $time, rsp_total_flow, rsp_storage_out);
            end else begin
               want = expected_flows.pop_front();
               check_field("total_flow", want.total, rsp_total_flow);
               check_field("fast_flow", want.fast, rsp_fast_flow);
               check_field("mid_flow", want.mid, rsp_mid_flow);
               check_field("base_flow", want.base, rsp_base_flow);
               check_field("storage_out", want.stor, rsp_storage_out);
               check_field("saturated", 32'(want.sat), 32'(rsp_saturated));
               check_field("config_error", 32'(want.err), 32'(rsp_config_error));
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, expected_flows.size());
         $display("FAIL hbv_reservoir_three_outlet_routing");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Write one register; call right after a rising edge while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INIT_STORAGE: cfg_init  = val;
         CSR_FAST_COEF:    cfg_fast  = val[COEF_W-1:0];
         CSR_MID_COEF:     cfg_mid   = val[COEF_W-1:0];
         CSR_BASE_COEF:    cfg_base  = val[COEF_W-1:0];
         CSR_UPPER_THR:    cfg_upper = val;
         CSR_PERC_THR:     cfg_perc  = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [DATA_W-1:0] init, input logic [DATA_W-1:0] f,
                                input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] b,
                                input logic [DATA_W-1:0] up, input logic [DATA_W-1:0] pc);
      n_settings++;
      write_reg(CSR_INIT_STORAGE, init);
      write_reg(CSR_FAST_COEF, f);
      write_reg(CSR_MID_COEF, m);
      write_reg(CSR_BASE_COEF, b);
      write_reg(CSR_UPPER_THR, up);
      write_reg(CSR_PERC_THR, pc);
   endtask

   // Queue the directed items plus random ones, then wait until all results are back
   task automatic feed(input int n_random, input int mode, input bit squeeze);
      logic [DATA_W-1:0] v;
      int                target;
      @(negedge clock);
      case (mode)
         MODE_SENDER_GAPS:     begin sender_idle_pct = 52; stall_pct = 0;  end
         MODE_RECEIVER_STALLS: begin sender_idle_pct = 0;  stall_pct = 52; end
         MODE_BOTH:            begin sender_idle_pct = 12; stall_pct = 12; end
         default:              begin sender_idle_pct = 0;  stall_pct = 0;  end
      endcase
      while (directed_runoff.size() != 0)
         runoff_backlog.push_back(directed_runoff.pop_front());
      repeat (n_random) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 32'h0004_0000);
            4, 5:       v = '0;
            6:          v = $urandom;
            7:          v = FULL_SCALE - $urandom_range(0, 255);
            default:    v = cfg_upper + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         endcase
         runoff_backlog.push_back(v);
      end
      // every queued beat must come back as a checked result
      target = n_results + runoff_backlog.size();
      if (squeeze) hold_requests <= hold_requests + 1;
      @(posedge clock);
      while (n_results < target)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int c1;
      int c2;
      int c3;
      logic [DATA_W-1:0] pc;
      logic [DATA_W-1:0] up;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Bad coefficient order before the first item: storage reads back the initial value
      write_reg(CSR_INIT_STORAGE, 32'h0020_0000);
      write_reg(CSR_FAST_COEF, MID_COEF_RESET);
      directed_runoff = '{32'h0000_0000, 32'hFFFF_FFFF};
      feed(0, MODE_STEADY, 1'b0);

      // Fix the order with junk in the upper coefficient bits; first item loads storage
      write_reg(CSR_FAST_COEF, 32'hABCD_9999);
      n_settings++;
      directed_runoff = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                          32'h0000_0001, 32'h0001_8000, 32'h0000_0000, 32'h0000_0000};
      feed(0, MODE_STEADY, 1'b0);

      // Mid coefficient equal to base, then thresholds equal
      write_reg(CSR_MID_COEF, BASE_COEF_RESET);
      directed_runoff = '{32'h1234_5678};
      feed(0, MODE_STEADY, 1'b0);
      write_reg(CSR_MID_COEF, MID_COEF_RESET);
      write_reg(CSR_UPPER_THR, PERC_THR_RESET);
      directed_runoff = '{32'hFFFF_FFFF};
      feed(0, MODE_STEADY, 1'b0);
      write_reg(CSR_UPPER_THR, UPPER_THR_RESET);

      // Random phases, each with its own register setting and idling scheme
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         c1 = $urandom_range(2, 65535);
         c2 = $urandom_range(1, c1 - 1);
         c3 = $urandom_range(0, c2 - 1);
         pc = $urandom_range(0, 32'h0100_0000);
         up = pc + $urandom_range(1, 32'h0200_0000);
         case (p)
            1: load_settings(FULL_SCALE, 32'h0000_FFFF, 32'h0000_FFFE, 32'h0000_FFFD,
                             FULL_SCALE, FULL_SCALE - 1);
            3: load_settings('0, 32'h0000_0002, 32'h0000_0001, '0, 32'h0000_0001, '0);
            5: load_settings($urandom, c1, c1, c3, up, pc);
            default: load_settings($urandom, {16'($urandom), 16'(c1)},
                                   {16'($urandom), 16'(c2)}, {16'($urandom), 16'(c3)},
                                   up, pc);
         endcase
         feed(PHASE_ITEMS, p % 4, p == 2);
      end

      $display("Checked %0d routing results over %0d register settings:",
               n_results, n_settings);
      $display("%0d fast-band, %0d mid-band, %0d base-only steps; %0d clipped, %0d bad order.",
               n_fast_steps, n_mid_steps, n_base_steps, n_clipped, n_order_err);
      if (failures == 0) begin
         $display("PASS hbv_reservoir_three_outlet_routing");
      end else begin
         $display("FAIL hbv_reservoir_three_outlet_routing");
      end
      $finish;
   end

endmodule

### filelist.f
sv/hbvr_pkg.sv
sv/hbv_reservoir_three_outlet_routing.sv
bench/tb_hbv_reservoir_three_outlet_routing.sv
